// ===== sv/awt_pkg.sv =====
// ----------------------------------------------------------------------------
// awt_pkg
// Shared types and codes for the card authorization whitelist table.
// ----------------------------------------------------------------------------
package awt_pkg;

    // item opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // lookup result codes
    localparam logic [1:0] LK_NOT_FOUND = 2'd0;
    localparam logic [1:0] LK_ACCEPTED  = 2'd1;
    localparam logic [1:0] LK_REJECTED  = 2'd2;
    localparam logic [1:0] LK_EXPIRED   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_ENTRIES   = 2'd0;
    localparam logic [1:0] CFG_ACCEPTED_CODE = 2'd1;
    localparam logic [1:0] CFG_CONFLICT_EN   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        first_of_batch;
        logic        last_of_batch;
        logic        full_replace;
        logic [63:0] card_tag;
        logic [2:0]  card_status;
        logic [31:0] expiry_time;
        logic [31:0] entry_age_stamp;
        logic [31:0] now_time;
    } req_t;

    typedef struct packed {
        logic [1:0] lookup_code;
        logic       conflict;
        logic [4:0] entry_count;
        logic       table_emptied;
    } resp_t;

    typedef struct packed {
        logic [4:0] max_entries;
        logic [2:0] accepted_code;
        logic       conflict_check_enable;
    } cfg_t;

endpackage

// ===== sv/awt_ram.sv =====
// ----------------------------------------------------------------------------
// awt_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module awt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/awt_cfg.sv =====
// ----------------------------------------------------------------------------
// awt_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module awt_cfg
    import awt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_entries           <= 5'd16;
            cfg_reg.accepted_code         <= 3'd1;
            cfg_reg.conflict_check_enable <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_ENTRIES:   cfg_reg.max_entries           <= cfg_data;
                CFG_ACCEPTED_CODE: cfg_reg.accepted_code         <= cfg_data[2:0];
                CFG_CONFLICT_EN:   cfg_reg.conflict_check_enable <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/auth_whitelist_table.sv =====
// ----------------------------------------------------------------------------
// auth_whitelist_table
// Card authorization whitelist held in one entry RAM, scanned by a sequencer.
// ----------------------------------------------------------------------------
// Sequence: a clear goes straight to the output stage; a lookup scans the held
//   entries until a hit or the end; a load scans until a hit or the end, plus
//   a compaction pass over the held entries when it ends a batch.
// Throughput: one transaction at a time; the entry scan, one RAM read per
//   entry, sets the rate.
// Reset: count, delete marks and configuration reset; the RAM is not cleared.
module auth_whitelist_table
    import awt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int TAG_BITS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  req_t       in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output resp_t      out_data,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = TAG_BITS + 67;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_DEC  = 7'b0001000,
        S_CRD  = 7'b0010000,
        S_CWR  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    cfg_t cfg;

    state_t                 state_reg, state_next;
    req_t                   req_reg, req_next;
    resp_t                  res_reg, res_next;
    resp_t                  out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          wr_reg, wr_next;
    logic [CW-1:0]          held_reg, held_next;
    logic [TABLE_DEPTH-1:0] marks_reg, marks_next;
    logic                   hit_reg, hit_next;
    logic [AW-1:0]          hit_idx_reg, hit_idx_next;
    logic                   mk_reg, mk_next;
    logic [AW-1:0]          mk_idx_reg, mk_idx_next;
    logic                   vic_done_reg, vic_done_next;
    logic [AW-1:0]          vic_idx_reg, vic_idx_next;
    logic [31:0]            vic_stamp_reg, vic_stamp_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [TAG_BITS-1:0] rd_tag;
    logic [2:0]          rd_status;
    logic [31:0]         rd_expiry, rd_stamp;
    logic                tag_match;
    logic [CW+4:0]       cap_wide, held_wide, max_wide;
    logic [CW+4:0]       count_wide;
    logic [AW-1:0]       idx_addr;
    logic [EW-1:0]       new_entry;

    awt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    awt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry fields from the read port
    assign rd_stamp  = ram_rdata[31:0];
    assign rd_expiry = ram_rdata[63:32];
    assign rd_status = ram_rdata[66:64];
    assign rd_tag    = ram_rdata[EW-1:67];
    assign tag_match = (rd_tag == req_reg.card_tag[TAG_BITS-1:0]);
    assign idx_addr  = idx_reg[AW-1:0];
    assign new_entry = {req_reg.card_tag[TAG_BITS-1:0], req_reg.card_status,
                        req_reg.expiry_time, req_reg.entry_age_stamp};

    // effective capacity: zero acts as one, clipped to the table depth
    always_comb
    begin
        max_wide  = {{CW{1'b0}}, cfg.max_entries};
        held_wide = {5'd0, held_reg};
        if (max_wide == '0)
        begin
            cap_wide = (CW + 5)'(1);
        end
        else if (max_wide > (CW + 5)'(TABLE_DEPTH))
        begin
            cap_wide = (CW + 5)'(TABLE_DEPTH);
        end
        else
        begin
            cap_wide = max_wide;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        wr_next        = wr_reg;
        held_next      = held_reg;
        marks_next     = marks_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        mk_next        = mk_reg;
        mk_idx_next    = mk_idx_reg;
        vic_done_next  = vic_done_reg;
        vic_idx_next   = vic_idx_reg;
        vic_stamp_next = vic_stamp_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_addr;
        ram_wdata      = new_entry;
        ram_raddr      = idx_addr;
        count_wide     = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = in_data;
                    res_next      = '0;
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    mk_next       = 1'b0;
                    vic_done_next = 1'b0;
                    vic_idx_next  = '0;
                    state_next    = S_OUT;
                    if (in_data.opcode == OP_CLEAR)
                    begin
                        held_next  = '0;
                        marks_next = '0;
                    end
                    else if (in_data.opcode == OP_LOAD)
                    begin
                        state_next = S_RD;
                        if (in_data.first_of_batch)
                        begin
                            marks_next = '0;
                            if (in_data.full_replace)
                            begin
                                held_next = '0;
                            end
                        end
                    end
                    else if (in_data.opcode == OP_LOOKUP)
                    begin
                        state_next = S_RD;
                    end
                end
            end

            // issue a read or end the scan
            S_RD:
            begin
                if (idx_reg == held_reg)
                begin
                    state_next = (req_reg.opcode == OP_LOAD) ? S_DEC : S_OUT;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end

            // examine one entry
            S_CMP:
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = S_RD;
                if (req_reg.opcode == OP_LOOKUP)
                begin
                    if (tag_match)
                    begin
                        state_next = S_OUT;
                        if (rd_status == cfg.accepted_code)
                        begin
                            res_next.lookup_code =
                                (rd_expiry == '0 || rd_expiry > req_reg.now_time)
                                ? LK_ACCEPTED : LK_EXPIRED;
                        end
                        else
                        begin
                            res_next.lookup_code = LK_REJECTED;
                        end
                        res_next.conflict = cfg.conflict_check_enable &&
                            !(rd_status == req_reg.card_status &&
                              (req_reg.expiry_time == '0 ||
                               rd_expiry == req_reg.expiry_time));
                    end
                end
                else if (tag_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_addr;
                    state_next   = S_DEC;
                end
                else
                begin
                    if (marks_reg[idx_addr] && !mk_reg)
                    begin
                        mk_next     = 1'b1;
                        mk_idx_next = idx_addr;
                    end
                    if (!vic_done_reg)
                    begin
                        if (rd_status != cfg.accepted_code)
                        begin
                            vic_idx_next  = idx_addr;
                            vic_done_next = 1'b1;
                        end
                        else if (idx_reg == '0 || rd_stamp < vic_stamp_reg)
                        begin
                            vic_idx_next   = idx_addr;
                            vic_stamp_next = rd_stamp;
                        end
                    end
                end
            end

            // place the loaded entry, or mark a matched entry for deletion
            S_DEC:
            begin
                if (hit_reg)
                begin
                    if (!req_reg.full_replace && req_reg.expiry_time == '0 &&
                        req_reg.card_status == '0)
                    begin
                        marks_next[hit_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = hit_idx_reg;
                    end
                end
                else if (mk_reg)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = mk_idx_reg;
                    marks_next[mk_idx_reg] = 1'b0;
                end
                else if (held_wide < cap_wide)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = held_reg[AW-1:0];
                    held_next = held_reg + CW'(1);
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = vic_idx_reg;
                end
                idx_next   = '0;
                wr_next    = '0;
                state_next = req_reg.last_of_batch ? S_CRD : S_OUT;
            end

            // compaction read
            S_CRD:
            begin
                if (idx_reg == held_reg)
                begin
                    held_next              = wr_reg;
                    marks_next             = '0;
                    res_next.table_emptied = (wr_reg == '0);
                    state_next             = S_OUT;
                end
                else
                begin
                    state_next = S_CWR;
                end
            end

            // compaction move of a kept entry
            S_CWR:
            begin
                if (!marks_reg[idx_addr])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    wr_next   = wr_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_CRD;
            end

            // hand the result to the output register
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    count_wide           = {5'd0, held_reg};
                    out_next             = res_reg;
                    out_next.entry_count = count_wide[4:0];
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            marks_reg     <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            hit_reg       <= 1'b0;
            mk_reg        <= 1'b0;
            vic_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            marks_reg     <= marks_next;
            idx_reg       <= idx_next;
            wr_reg        <= wr_next;
            hit_reg       <= hit_next;
            mk_reg        <= mk_next;
            vic_done_reg  <= vic_done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        hit_idx_reg   <= hit_idx_next;
        mk_idx_reg    <= mk_idx_next;
        vic_idx_reg   <= vic_idx_next;
        vic_stamp_reg <= vic_stamp_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/awt_checker.sv =====
// ----------------------------------------------------------------------------
// awt_checker
// Port-level checks on the whitelist table, bound to the top level.
// ----------------------------------------------------------------------------
module awt_checker
    import awt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input logic  clk,
    input logic  rst_n,
    input logic  out_valid,
    input logic  out_ready,
    input resp_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // count never exceeds the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(out_data.entry_count) <= TABLE_DEPTH)
        else $error("entry count above table depth");

    // an emptied table reports no entries
    a_emptied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.table_emptied |-> out_data.entry_count == '0)
        else $error("emptied with entries left");

    // conflict only on a found entry
    a_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.conflict |-> out_data.lookup_code != LK_NOT_FOUND)
        else $error("conflict without a hit");

endmodule

bind auth_whitelist_table awt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_awt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/sv/auth_whitelist_table_test.sv =====
// ----------------------------------------------------------------------------
// auth_whitelist_table_test
// Self-checking bench for the card whitelist: a behavioral table model
// predicts every response, directed tests cover batch modes, replacement,
// compaction and lookup conflicts, then random batches and lookups run
// under several register settings, most with random idling on both channels.
// ----------------------------------------------------------------------------
module auth_whitelist_table_test;
    import awt_pkg::*;

    localparam int DEPTH      = 16;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 80;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    req_t       in_data;
    logic       out_valid;
    logic       out_ready;
    resp_t      out_data;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;

    auth_whitelist_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // model of the table
    logic [63:0] wl_tag    [DEPTH];
    logic [2:0]  wl_status [DEPTH];
    logic [31:0] wl_expiry [DEPTH];
    logic [31:0] wl_stamp  [DEPTH];
    logic        wl_mark   [DEPTH];
    int          wl_count;
    logic [4:0]  cur_max_entries;
    logic [2:0]  cur_accepted;
    logic        cur_conflict_en;

    resp_t expected_resp[$];
    int    error_count;
    int    resp_count;
    int    lookup_hits;
    int    emptied_seen;
    int    stall_cycles;
    bit    idle_enable;

    // recent tags reused so loads and lookups hit existing entries
    logic [63:0] tag_pool[$];

    function automatic int find_entry(input logic [63:0] tag);
        for (int i = 0; i < wl_count; i++)
            if (wl_tag[i] == tag)
                return i;
        return -1;
    endfunction

    function automatic void write_entry(input int slot, input req_t r);
        wl_tag[slot]    = r.card_tag;
        wl_status[slot] = r.card_status;
        wl_expiry[slot] = r.expiry_time;
        wl_stamp[slot]  = r.entry_age_stamp;
    endfunction

    function automatic void apply_load(input req_t r);
        int hit;
        int cap;
        int victim;
        if (r.first_of_batch)
        begin
            for (int i = 0; i < DEPTH; i++)
                wl_mark[i] = 1'b0;
            if (r.full_replace)
                wl_count = 0;
        end
        hit = find_entry(r.card_tag);
        if (hit >= 0)
        begin
            if (!r.full_replace && r.expiry_time == 0 && r.card_status == 0)
                wl_mark[hit] = 1'b1;
            else
                write_entry(hit, r);
            return;
        end
        for (int k = 0; k < wl_count; k++)
            if (wl_mark[k])
            begin
                write_entry(k, r);
                wl_mark[k] = 1'b0;
                return;
            end
        cap = (cur_max_entries == 0) ? 1 :
              (cur_max_entries > DEPTH) ? DEPTH : int'(cur_max_entries);
        if (wl_count < cap)
        begin
            write_entry(wl_count, r);
            wl_count++;
            return;
        end
        victim = 0;
        for (int m = 0; m < wl_count; m++)
        begin
            if (wl_status[m] != cur_accepted)
            begin
                victim = m;
                break;
            end
            if (wl_stamp[m] < wl_stamp[victim])
                victim = m;
        end
        write_entry(victim, r);
    endfunction

    function automatic void compact_table();
        int w;
        w = 0;
        for (int k = 0; k < wl_count; k++)
            if (!wl_mark[k])
            begin
                wl_tag[w]    = wl_tag[k];
                wl_status[w] = wl_status[k];
                wl_expiry[w] = wl_expiry[k];
                wl_stamp[w]  = wl_stamp[k];
                w++;
            end
        wl_count = w;
        for (int i = 0; i < DEPTH; i++)
            wl_mark[i] = 1'b0;
    endfunction

    // expected response for one accepted request, state updated in place
    function automatic resp_t predict_whitelist(input req_t r);
        resp_t res;
        int    hit;
        res = '0;
        case (r.opcode)
            OP_CLEAR:
            begin
                wl_count = 0;
                for (int i = 0; i < DEPTH; i++)
                    wl_mark[i] = 1'b0;
            end
            OP_LOAD:
            begin
                apply_load(r);
                if (r.last_of_batch)
                begin
                    compact_table();
                    res.table_emptied = (wl_count == 0);
                end
            end
            OP_LOOKUP:
            begin
                hit = find_entry(r.card_tag);
                if (hit >= 0)
                begin
                    if (wl_status[hit] == cur_accepted)
                        res.lookup_code = (wl_expiry[hit] == 0 || wl_expiry[hit] > r.now_time)
                                          ? LK_ACCEPTED : LK_EXPIRED;
                    else
                        res.lookup_code = LK_REJECTED;
                    if (cur_conflict_en && !(wl_status[hit] == r.card_status &&
                        (r.expiry_time == 0 || wl_expiry[hit] == r.expiry_time)))
                        res.conflict = 1'b1;
                end
            end
            default: ;
        endcase
        res.entry_count = wl_count[4:0];
        return res;
    endfunction

    // response checker and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_MAX);
                $display("[auth_whitelist_table] ERROR");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                resp_count++;
                if (out_data.table_emptied)
                    emptied_seen++;
                if (expected_resp.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected response %p", out_data);
                end
                else
                begin
                    resp_t want;
                    want = expected_resp.pop_front();
                    if (out_data.lookup_code !== want.lookup_code ||
                        out_data.conflict !== want.conflict ||
                        out_data.entry_count !== want.entry_count ||
                        out_data.table_emptied !== want.table_emptied)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch #%0d: expected %p, got %p",
                                     resp_count, want, out_data);
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= idle_enable ? ($urandom_range(99) >= 18) : 1'b1;

    task automatic send_item(input req_t r);
        if (idle_enable)
            while ($urandom_range(99) < 18)
                @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_resp.push_back(predict_whitelist(r));
        if (r.opcode == OP_LOOKUP && expected_resp[$].lookup_code != LK_NOT_FOUND)
            lookup_hits++;
        in_valid <= 1'b0;
        // the block leaves the idle state when it takes a transaction, so in_ready drops
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_resp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_MAX_ENTRIES:   cur_max_entries = val;
            CFG_ACCEPTED_CODE: cur_accepted    = val[2:0];
            CFG_CONFLICT_EN:   cur_conflict_en = val[0];
            default: ;
        endcase
    endtask

    function automatic req_t make_item(input logic [1:0] op, input logic [63:0] tag,
                                       input logic [2:0] st, input logic [31:0] ex);
        req_t r;
        r = '0;
        r.opcode          = op;
        r.card_tag        = tag;
        r.card_status     = st;
        r.expiry_time     = ex;
        r.entry_age_stamp = $urandom;
        r.now_time        = $urandom;
        return r;
    endfunction

    task automatic send_load(input logic [63:0] tag, input logic [2:0] st,
                             input logic [31:0] ex, input bit first, input bit last,
                             input bit full);
        req_t r;
        r = make_item(OP_LOAD, tag, st, ex);
        r.first_of_batch = first;
        r.last_of_batch  = last;
        r.full_replace   = full;
        send_item(r);
    endtask

    task automatic send_lookup(input logic [63:0] tag, input logic [2:0] st,
                               input logic [31:0] ex, input logic [31:0] now_t);
        req_t r;
        r = make_item(OP_LOOKUP, tag, st, ex);
        r.now_time = now_t;
        send_item(r);
    endtask

    function automatic logic [63:0] random_tag();
        if (tag_pool.size() != 0 && $urandom_range(99) < 60)
            return tag_pool[$urandom_range(tag_pool.size() - 1)];
        random_tag = {$urandom, $urandom};
        tag_pool.push_back(random_tag);
        if (tag_pool.size() > 24)
            void'(tag_pool.pop_front());
    endfunction

    // directed: field extremes, every opcode, batch modes, lookups
    task automatic test_directed();
        req_t r;
        send_lookup(64'h0, 3'd0, 32'd0, 32'd0);
        send_load(64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 1, 0, 1);
        send_load(64'h0, 3'd1, 32'd0, 0, 0, 1);
        send_load(64'h1234, 3'd1, 32'd100, 0, 1, 1);
        send_lookup(64'h0, 3'd1, 32'd0, 32'hFFFF_FFFF);
        send_lookup(64'h1234, 3'd1, 32'd100, 32'd99);
        send_lookup(64'h1234, 3'd1, 32'd100, 32'd100);
        send_lookup(64'h1234, 3'd2, 32'd5, 32'd0);
        send_lookup(64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'd0);
        // diff batch: delete, mark then rewrite, lookup mid-batch
        send_load(64'h1234, 3'd0, 32'd0, 1, 0, 0);
        send_lookup(64'h1234, 3'd1, 32'd0, 32'd0);
        send_load(64'h0, 3'd0, 32'd0, 0, 0, 0);
        send_load(64'h0, 3'd3, 32'd7, 0, 0, 0);
        send_load(64'h5555, 3'd0, 32'd0, 0, 1, 0);
        // unused opcode and clear
        r = make_item(2'd3, 64'h5555, 3'd5, 32'd1);
        r.first_of_batch = 1'b1;
        r.last_of_batch  = 1'b1;
        send_item(r);
        r = make_item(OP_CLEAR, 64'h0, 3'd0, 32'd0);
        send_item(r);
        // batch ending empty
        send_load(64'h77, 3'd1, 32'd0, 1, 0, 1);
        send_load(64'h77, 3'd0, 32'd0, 0, 1, 0);
    endtask

    // filling past capacity exercises the victim choice
    task automatic test_replacement(input int n);
        for (int i = 0; i < n; i++)
            send_load({$urandom, $urandom}, ($urandom_range(3) == 0) ? 3'd2 : cur_accepted,
                      $urandom, i == 0, i == n - 1, 1);
    endtask

    task automatic test_random(input int n);
        int sent;
        int len;
        bit full;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_item(make_item(2'($urandom_range(3)), random_tag(),
                                    3'($urandom), $urandom));
                sent++;
                continue;
            end
            len  = $urandom_range(1, 6);
            full = ($urandom_range(3) == 0);
            for (int i = 0; i < len; i++)
            begin
                bit del;
                del = !full && $urandom_range(3) == 0;
                send_load(random_tag(), del ? 3'd0 : 3'($urandom_range(7)),
                          del ? 32'd0 : (($urandom_range(3) == 0) ? 32'd0 : $urandom),
                          i == 0, (i == len - 1) || $urandom_range(19) == 0, full);
                sent++;
                if ($urandom_range(3) == 0)
                begin
                    send_lookup(random_tag(), 3'($urandom_range(7)),
                                ($urandom_range(1)) ? 32'd0 : $urandom, $urandom);
                    sent++;
                end
            end
            repeat ($urandom_range(1, 3))
            begin
                send_lookup(random_tag(), 3'($urandom_range(7)),
                            ($urandom_range(1)) ? 32'd0 : $urandom, $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b1;
        cfg_write   = 1'b0;
        cfg_index   = CFG_MAX_ENTRIES;
        cfg_data    = '0;
        idle_enable = 1'b0;
        error_count = 0;
        resp_count  = 0;
        lookup_hits = 0;
        emptied_seen = 0;
        stall_cycles = 0;
        wl_count    = 0;
        for (int i = 0; i < DEPTH; i++)
            wl_mark[i] = 1'b0;
        cur_max_entries = 5'd16;
        cur_accepted    = 3'd1;
        cur_conflict_en = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no idling during the directed part
        test_directed();
        idle_enable = 1'b1;
        test_replacement(20);
        wait_drained();

        write_reg(CFG_MAX_ENTRIES, 5'd4);
        write_reg(CFG_ACCEPTED_CODE, 5'd0);
        write_reg(CFG_CONFLICT_EN, 5'd0);
        test_replacement(8);
        test_random(150);

        write_reg(CFG_MAX_ENTRIES, 5'd0);
        write_reg(CFG_ACCEPTED_CODE, 5'd7);
        write_reg(CFG_CONFLICT_EN, 5'd1);
        test_random(100);

        // lowering capacity below the held count
        write_reg(CFG_MAX_ENTRIES, 5'd31);
        test_replacement(18);
        write_reg(CFG_MAX_ENTRIES, 5'd3);
        test_random(120);

        write_reg(CFG_MAX_ENTRIES, 5'd16);
        write_reg(CFG_ACCEPTED_CODE, 5'd1);
        idle_enable = 1'b0;
        test_random(120);
        idle_enable = 1'b1;
        test_random(150);

        wait_drained();
        $display("covered %0d responses, %0d lookup hits, %0d batches ending empty",
                 resp_count, lookup_hits, emptied_seen);
        $display("register settings swept over capacity, accepted code and conflict check");
        if (error_count == 0)
            $display("[auth_whitelist_table] OK");
        else
            $display("[auth_whitelist_table] ERROR");
        $finish;
    end

endmodule

// ===== auth_whitelist_table.f =====
sv/awt_pkg.sv
sv/awt_ram.sv
sv/awt_cfg.sv
sv/auth_whitelist_table.sv
sv/awt_checker.sv
tb/sv/auth_whitelist_table_test.sv
